// ----- rtl/mcis_pkg.sv -----
// Shared types and constants for the multi-client interval scheduler.
// No dependencies; used by mcis_table and the top level.
package mcis_pkg;

  // most slots that may fire on one tick
  localparam int MAX_RESULTS = 16;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
  localparam int RES_IW      = $clog2(MAX_RESULTS);

  localparam logic [15:0] MIN_PERIOD_RST = 16'd1;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXPIRED   = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

  // one slot of the table memory
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] period;
    logic        once;
  } entry_t;

endpackage

// ----- rtl/mcis_table.sv -----
// Slot table memory: due time, period and one-shot flag per slot.
// One write port, one read port, registered read data. Uses mcis_pkg.
module mcis_table #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  mcis_pkg::entry_t             wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output mcis_pkg::entry_t             rd_data
);

  mcis_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/multi_client_interval_scheduler.sv -----
// Multi-client interval scheduler, top level.
// Holds the control sequencer, armed flags and output register; the slot
// table lives in mcis_table. Uses mcis_pkg.
//
// Usage:
//  Input words arrive on s_*: s_tuser is the opcode (0 schedule/cancel,
//  1 tick). A schedule word arms, re-arms or (period 0) cancels one slot and
//  answers with one result word. A tick word reports every armed slot whose
//  due time is at or below now_ms, earliest due first, ties by slot number,
//  at most 16 per tick; m_tlast marks the final word of the item. A tick
//  with nothing due gives one word with status 3.
//  cfg_* writes min_period; cfg_ready is always high. Write it while idle.
//  Sequence: a schedule item goes from S_SCHED to S_EMIT. A tick that fires
//  k slots runs min(k+1, 16) scan passes over the table, each reading every
//  slot as the single table read port visits one slot per cycle, then gives
//  max(k, 1) result words. One item is worked on at a time; s_tready is high
//  between items, also while the last result word still waits.
//  A stalled m_tready holds the output word and the sequencer.
//  Reset clears all armed flags and sets min_period to 1; the table
//  contents need no clearing.
module multi_client_interval_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // client_slot[3:0], period[35:4], one_shot[36], now_ms[68:37]
  input  logic [0:0]  s_tuser,   // opcode[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status[1:0], fired_slot[5:2], timer_active[6]
  output logic        m_tlast,
  // min_period write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int RCW = mcis_pkg::RES_CW;
  localparam int RIW = mcis_pkg::RES_IW;

  mcis_pkg::state_t state, state_next;

  logic [15:0]        min_period;
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] picked;
  logic [CW-1:0]      armed_cnt;

  // captured input word
  mcis_pkg::opcode_t  in_op;
  logic [3:0]         in_slot;
  logic [31:0]        in_period;
  logic               in_once;
  logic [31:0]        in_now;

  // scan pass
  logic [SW-1:0]      scan_addr;
  logic               scan_issue;
  logic               rd_valid;
  logic [SW-1:0]      rd_idx;
  mcis_pkg::entry_t   rd_data;
  logic               found;
  logic [SW-1:0]      best_idx;
  logic [31:0]        best_due;
  logic [31:0]        best_period;
  logic               best_once;

  // pick list and emit
  logic [SW-1:0]      order [mcis_pkg::MAX_RESULTS];
  logic [RCW-1:0]     n_picked;
  logic [RCW-1:0]     emit_cnt;
  logic               single;
  mcis_pkg::status_t  res_status;

  // combinational control
  logic               in_fire;
  logic               rd_en;
  logic               cand;
  logic               pass_done;
  logic               out_free;
  logic               out_load;
  logic               last_emit;
  logic               slot_ok;
  logic [SW-1:0]      sched_idx;
  logic [31:0]        per_clamped;
  logic               wr_en;
  logic [SW-1:0]      wr_addr;
  mcis_pkg::entry_t   wr_data;
  logic               more_room;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == mcis_pkg::S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign rd_en     = (state == mcis_pkg::S_SCAN) && scan_issue;
  assign out_free  = !m_tvalid || m_tready;
  assign pass_done = rd_valid && (rd_idx == SW'(NUM_SLOTS - 1));
  assign last_emit = single || ((emit_cnt + RCW'(1)) == n_picked);
  assign more_room = (n_picked + RCW'(1)) < RCW'(mcis_pkg::MAX_RESULTS);

  assign slot_ok   = 32'(in_slot) < 32'(NUM_SLOTS);
  assign sched_idx = SW'(in_slot);
  assign per_clamped = (in_period < {16'd0, min_period}) ? {16'd0, min_period} : in_period;

  assign cand = rd_valid && armed[rd_idx] && !picked[rd_idx] && (rd_data.due <= in_now)
                && (!found || (rd_data.due < best_due));

  // table write: arm from a schedule word, or advance a periodic slot that fired
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sched_idx;
    wr_data = '{due: in_now + per_clamped, period: per_clamped, once: in_once};
    if (state == mcis_pkg::S_SCHED) begin
      wr_en = slot_ok && (in_period != 32'd0);
    end else if (state == mcis_pkg::S_DECIDE) begin
      wr_en   = found && !best_once;
      wr_addr = best_idx;
      wr_data = '{due: best_due + best_period, period: best_period, once: best_once};
    end
  end

  mcis_table #(
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcis_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      mcis_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = (s_tuser[0] == mcis_pkg::OP_TICK) ? mcis_pkg::S_SCAN
                                                         : mcis_pkg::S_SCHED;
        end
      end
      mcis_pkg::S_SCHED: begin
        state_next = mcis_pkg::S_EMIT;
      end
      mcis_pkg::S_SCAN: begin
        if (pass_done) begin
          state_next = mcis_pkg::S_DECIDE;
        end
      end
      mcis_pkg::S_DECIDE: begin
        state_next = (found && more_room) ? mcis_pkg::S_SCAN : mcis_pkg::S_EMIT;
      end
      mcis_pkg::S_EMIT: begin
        out_load = out_free;
        if (out_free && last_emit) begin
          state_next = mcis_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mcis_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period <= mcis_pkg::MIN_PERIOD_RST;
      armed      <= '0;
      armed_cnt  <= '0;
      picked     <= '0;
      scan_issue <= 1'b0;
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
      n_picked   <= '0;
      emit_cnt   <= '0;
      single     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        min_period <= cfg_data;
      end
      rd_valid <= rd_en;

      if (in_fire) begin
        picked     <= '0;
        n_picked   <= '0;
        emit_cnt   <= '0;
        found      <= 1'b0;
        scan_issue <= (s_tuser[0] == mcis_pkg::OP_TICK);
      end

      if (rd_en && (scan_addr == SW'(NUM_SLOTS - 1))) begin
        scan_issue <= 1'b0;
      end
      if (cand) begin
        found <= 1'b1;
      end

      if (state == mcis_pkg::S_SCHED) begin
        single <= 1'b1;
        if (slot_ok && (in_period != 32'd0)) begin
          armed[sched_idx] <= 1'b1;
          if (!armed[sched_idx]) begin
            armed_cnt <= armed_cnt + CW'(1);
          end
        end else if (slot_ok) begin
          armed[sched_idx] <= 1'b0;
          if (armed[sched_idx]) begin
            armed_cnt <= armed_cnt - CW'(1);
          end
        end
      end

      if (state == mcis_pkg::S_DECIDE) begin
        found      <= 1'b0;
        scan_issue <= 1'b1;
        single     <= !found && (n_picked == '0);
        if (found) begin
          picked[best_idx] <= 1'b1;
          n_picked         <= n_picked + RCW'(1);
          // one-shot slots disarm; periodic ones were advanced in the table
          if (best_once) begin
            armed[best_idx] <= 1'b0;
            armed_cnt       <= armed_cnt - CW'(1);
          end
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        emit_cnt <= emit_cnt + RCW'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_op     <= mcis_pkg::opcode_t'(s_tuser[0]);
      in_slot   <= s_tdata[3:0];
      in_period <= s_tdata[35:4];
      in_once   <= s_tdata[36];
      in_now    <= s_tdata[68:37];
      scan_addr <= '0;
    end else if (state == mcis_pkg::S_DECIDE) begin
      scan_addr <= '0;
    end else if (rd_en) begin
      scan_addr <= scan_addr + SW'(1);
    end
    rd_idx <= scan_addr;

    if (cand) begin
      best_idx    <= rd_idx;
      best_due    <= rd_data.due;
      best_period <= rd_data.period;
      best_once   <= rd_data.once;
    end

    if ((state == mcis_pkg::S_DECIDE) && found) begin
      order[n_picked[RIW-1:0]] <= best_idx;
    end

    if (state == mcis_pkg::S_SCHED) begin
      if (!slot_ok) begin
        res_status <= mcis_pkg::ST_NOT_FOUND;
      end else if ((in_period == 32'd0) && !armed[sched_idx]) begin
        res_status <= mcis_pkg::ST_NOT_FOUND;
      end else begin
        res_status <= mcis_pkg::ST_OK;
      end
    end else if ((state == mcis_pkg::S_DECIDE) && (in_op == mcis_pkg::OP_TICK)) begin
      res_status <= mcis_pkg::ST_NONE_DUE;
    end

    if (out_load) begin
      m_tlast <= last_emit;
      if (single) begin
        m_tdata <= {1'b0, (armed_cnt != '0), 4'd0, res_status};
      end else begin
        m_tdata <= {1'b0, (armed_cnt != '0), 4'(order[emit_cnt[RIW-1:0]]),
                    mcis_pkg::ST_EXPIRED};
      end
    end
  end

  // an armed count of zero means that no slot is armed
  a_cnt_match: assert property (@(posedge clk) disable iff (rst)
    (armed_cnt == '0) |-> (armed == '0))
    else $error("armed count zero while a slot is armed");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    armed_cnt <= CW'(NUM_SLOTS))
    else $error("armed count beyond slot count");

  // a slot chosen in a pass is armed and was not chosen before
  a_pick_fresh: assert property (@(posedge clk) disable iff (rst)
    ((state == mcis_pkg::S_DECIDE) && found) |-> (armed[best_idx] && !picked[best_idx]))
    else $error("picked slot not armed or picked twice");

  a_pick_count: assert property (@(posedge clk) disable iff (rst)
    ((state == mcis_pkg::S_DECIDE) && found) |=> (n_picked == $past(n_picked) + RCW'(1)))
    else $error("pick count did not advance");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == mcis_pkg::S_EMIT) && !single) |-> (emit_cnt < n_picked))
    else $error("emitting past the pick list");

endmodule
